// ===== rtl/aarm_pkg.sv =====
`default_nettype none
package aarm_pkg;

  localparam int AngleW = 18;
  localparam int AxisW = 16;
  localparam int EntryW = 16;
  localparam int TrigIterMax = 24;
  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int HalfTurnDeg = 180;
  localparam int UnitsPerDeg = 256;
  localparam int FullTurn = 2 * HalfTurnDeg * UnitsPerDeg;
  localparam int HalfTurn = HalfTurnDeg * UnitsPerDeg;
  localparam int QuarterTurn = HalfTurn / 2;
  localparam logic signed [17:0] RadPerUnitQ30 = 18'sd73204;
  localparam logic signed [33:0] CordicInvGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam int EntryMax = 16384;

  // CORDIC working width: Q2.30 plus guard bits
  localparam int CW = 34;
  // square root operand: n2 (33 bits) << 28 = 61 bits, root 31 bits
  localparam int RootW = 31;
  // divider stages, one quotient bit each
  localparam int QuotW = 47;
  // unit vector component, Q2.30 magnitude below 2^31
  localparam int UnitW = 33;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aarm_cordic.sv =====
`default_nettype none
module aarm_cordic
  import aarm_pkg::*;
#(
  parameter int ITERS = TRIG_ITERATIONS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] z_in,
  output logic signed [CW-1:0]      sin_out,
  output logic signed [CW-1:0]      cos_out
);
  // one register stage per micro-rotation; the first stage is the start value
  localparam int N = (ITERS > TrigIterMax) ? TrigIterMax : ITERS;

  logic signed [CW-1:0] x_r [N+1];
  logic signed [CW-1:0] y_r [N+1];
  logic signed [CW-1:0] z_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CordicInvGain;
      y_r[0] <= '0;
      z_r[0] <= z_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
      end
    end
  end

  assign sin_out = y_r[N];
  assign cos_out = x_r[N];
endmodule
`default_nettype wire

// ===== rtl/aarm_norm.sv =====
`default_nettype none
module aarm_norm
  import aarm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [AxisW-1:0] ax,
  input  wire logic signed [AxisW-1:0] ay,
  input  wire logic signed [AxisW-1:0] az,
  output logic signed [UnitW-1:0]      ux,
  output logic signed [UnitW-1:0]      uy,
  output logic signed [UnitW-1:0]      uz
);
  // stage 0: squares; stage 1: sum; then 31 root stages, then 47 divider
  // stages (one quotient bit each); total depth 1+1+31+47 = 80
  localparam int SqW = 32;
  localparam int N2W = 33;
  localparam int RadW = 62;
  localparam int QW = QuotW;
  localparam int DenW = RootW;

  logic [SqW-1:0] sx_r, sy_r, sz_r;
  logic signed [AxisW-1:0] a0_r [3];
  logic [N2W-1:0] n2_r;
  logic signed [AxisW-1:0] a1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= SqW'(ax * ax);
      sy_r <= SqW'(ay * ay);
      sz_r <= SqW'(az * az);
      a0_r[0] <= ax; a0_r[1] <= ay; a0_r[2] <= az;
      n2_r <= N2W'(sx_r) + N2W'(sy_r) + N2W'(sz_r);
      a1_r <= a0_r;
    end
  end

  // restoring square root, one result bit per stage
  logic [RadW-1:0] rem_r [RootW+1];
  logic [RootW-1:0] root_r [RootW+1];
  logic [RadW-1:0] rad_r [RootW+1];
  logic signed [AxisW-1:0] ar_r [RootW+1][3];

  always_comb begin
    rad_r[0] = {1'b0, n2_r, 28'd0};
    rem_r[0] = '0;
    root_r[0] = '0;
    ar_r[0] = a1_r;
  end

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic [RadW-1:0] rem_t, trial;
    always_comb begin
      rem_t = {rem_r[k][RadW-3:0], rad_r[k][RadW-1:RadW-2]};
      trial = RadW'({root_r[k], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_t >= trial) begin
          rem_r[k+1] <= rem_t - trial;
          root_r[k+1] <= {root_r[k][RootW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= rem_t;
          root_r[k+1] <= {root_r[k][RootW-2:0], 1'b0};
        end
        rad_r[k+1] <= {rad_r[k][RadW-3:0], 2'b00};
        ar_r[k+1] <= ar_r[k];
      end
    end
  end

  // three restoring dividers sharing the stages: |a|<<44 / L, 47 quotient bits
  logic [QW-1:0] num_r [3][QW+1];
  logic [DenW:0] pr_r [3][QW+1];
  logic [QW-1:0] q_r [3][QW+1];
  logic sgn_r [3][QW+1];
  logic [DenW-1:0] den_r [QW+1];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic signed [AxisW-1:0] a_s;
    logic [AxisW-1:0] mag;
    always_comb begin
      a_s = ar_r[RootW][c];
      mag = a_s[AxisW-1] ? AxisW'(-a_s) : AxisW'(a_s);
      // |a|<<44 is 60 bits; its top 13 bits stay below L, so preload them
      num_r[c][0] = {mag[2:0], {(QW-3){1'b0}}};
      pr_r[c][0] = (DenW+1)'(mag[AxisW-1:3]);
      q_r[c][0] = '0;
      sgn_r[c][0] = a_s[AxisW-1];
    end
    for (genvar k = 0; k < QW; k++) begin : g_div
      logic [DenW+1:0] sh;
      always_comb sh = {pr_r[c][k], num_r[c][k][QW-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (sh >= (DenW+2)'(den_r[k])) begin
            pr_r[c][k+1] <= (DenW+1)'(sh - (DenW+2)'(den_r[k]));
            q_r[c][k+1] <= {q_r[c][k][QW-2:0], 1'b1};
          end else begin
            pr_r[c][k+1] <= (DenW+1)'(sh);
            q_r[c][k+1] <= {q_r[c][k][QW-2:0], 1'b0};
          end
          num_r[c][k+1] <= {num_r[c][k][QW-2:0], 1'b0};
          sgn_r[c][k+1] <= sgn_r[c][k];
        end
      end
    end
  end

  always_comb den_r[0] = (root_r[RootW] == '0) ? DenW'(1) : root_r[RootW];
  for (genvar k = 0; k < QW; k++) begin : g_den
    always_ff @(posedge clk) if (en) den_r[k+1] <= den_r[k];
  end

  assign ux = sgn_r[0][QW] ? -UnitW'(q_r[0][QW]) : UnitW'(q_r[0][QW]);
  assign uy = sgn_r[1][QW] ? -UnitW'(q_r[1][QW]) : UnitW'(q_r[1][QW]);
  assign uz = sgn_r[2][QW] ? -UnitW'(q_r[2][QW]) : UnitW'(q_r[2][QW]);
endmodule
`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix.sv =====
`default_nettype none
// Rodrigues rotation matrix from an angle (1/256 degree) and an unnormalized
// Q1.15 axis. Fully pipelined: one beat in per cycle while in_tready is high;
// a result beat passes through 87 pipeline stages (1 input/angle fold,
// 2 square/sum, 31 square-root bit stages, 47 divide bit stages, 6 matrix
// stages) and then the output skid buffer before it can be taken. The
// sine/cosine CORDIC runs alongside the normalizer, delayed to meet it.
// Entries are Q2.14 saturated to +-1.0; a zero axis gives a zero matrix with
// axis_zero set. A full stall freezes the whole pipeline, and a two-entry
// skid buffer on the output keeps in_tready independent of out_tready in the
// same cycle.
module axis_angle_rotation_matrix
  import aarm_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // angle_deg[17:0], axis_x[33:18], axis_y[49:34], axis_z[65:50], zero pad
  input  wire logic [71:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // m00,m01,m02,m10,m11,m12,m20,m21,m22 (16 bits each from bit 0), pad
  output logic [151:0]      out_tdata,
  // axis_zero
  output logic              out_tuser
);
  localparam int NIter = (TRIG_ITERATIONS > TrigIterMax) ? TrigIterMax : TRIG_ITERATIONS;
  localparam int NormLat = 2 + RootW + QuotW;
  localparam int CorLat = NIter + 1;
  localparam int MatLat = 6;
  localparam int Lat = 1 + NormLat + MatLat;
  localparam int OutW = 9 * EntryW;

  typedef struct packed {
    logic zero;
    logic neg_cos;
  } flags_t;

  logic en;
  logic [Lat-1:0] vld_r;
  logic res_valid;
  logic [OutW:0] res_data;

  // skid buffer, two entries
  logic [OutW:0] sk_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;

  // advance while the buffer has room for the beat leaving the pipeline
  assign in_tready = (cnt_r != 2'd2);
  assign en = in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Lat-2:0], in_tvalid};
  end
  assign res_valid = en && vld_r[Lat-1];

  // stage A: angle reduction (the modulo is a range fold over +-2 turns)
  logic signed [AngleW-1:0] ang;
  logic signed [AngleW+1:0] a0, a1;
  logic nc;
  always_comb begin
    ang = in_tdata[17:0];
    a0 = (AngleW+2)'(ang);
    // C remainder keeps the sign of the dividend
    if (a0 >= FullTurn) a0 = (AngleW+2)'(a0 - FullTurn);
    else if (a0 <= -FullTurn) a0 = (AngleW+2)'(a0 + FullTurn);
    if (a0 < 0) a0 = (AngleW+2)'(a0 + FullTurn);
    if (a0 > HalfTurn) a0 = (AngleW+2)'(a0 - FullTurn);
    nc = 1'b0;
    a1 = a0;
    if (a0 > QuarterTurn) begin
      a1 = (AngleW+2)'(HalfTurn - a0); nc = 1'b1;
    end else if (a0 < -QuarterTurn) begin
      a1 = (AngleW+2)'(-HalfTurn - a0); nc = 1'b1;
    end
  end

  logic signed [AngleW+1:0] fold_r;
  flags_t fl_r;
  logic signed [AxisW-1:0] ax_r, ay_r, az_r;
  always_ff @(posedge clk) begin
    if (en) begin
      fold_r <= a1;
      fl_r.neg_cos <= nc;
      fl_r.zero <= (in_tdata[65:18] == '0);
      ax_r <= in_tdata[33:18];
      ay_r <= in_tdata[49:34];
      az_r <= in_tdata[65:50];
    end
  end

  // angle to radians; delay so CORDIC finishes with the normalizer
  logic signed [CW-1:0] zrad;
  assign zrad = CW'(fold_r * RadPerUnitQ30);
  localparam int ZDel = NormLat - CorLat;
  logic signed [CW-1:0] zd_r [ZDel+1];
  assign zd_r[0] = zrad;
  for (genvar k = 0; k < ZDel; k++) begin : g_zd
    always_ff @(posedge clk) if (en) zd_r[k+1] <= zd_r[k];
  end

  logic signed [CW-1:0] s_w, c_w;
  aarm_cordic #(.ITERS(TRIG_ITERATIONS)) u_cordic (
    .clk(clk), .en(en), .z_in(zd_r[ZDel]),
    .sin_out(s_w), .cos_out(c_w)
  );

  logic signed [UnitW-1:0] ux, uy, uz;
  aarm_norm u_norm (
    .clk(clk), .en(en), .ax(ax_r), .ay(ay_r), .az(az_r),
    .ux(ux), .uy(uy), .uz(uz)
  );

  flags_t fd_r [NormLat+1];
  assign fd_r[0] = fl_r;
  for (genvar k = 0; k < NormLat; k++) begin : g_fd
    always_ff @(posedge clk) if (en) fd_r[k+1] <= fd_r[k];
  end

  // matrix stages
  logic signed [UnitW-1:0] u1_r [3];
  logic signed [CW-1:0] s1_r, c1_r;
  flags_t f1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      u1_r[0] <= ux; u1_r[1] <= uy; u1_r[2] <= uz;
      s1_r <= s_w;
      c1_r <= fd_r[NormLat].neg_cos ? -c_w : c_w;
      f1_r <= fd_r[NormLat];
    end
  end

  // full products u_i*u_j and s*u_i; the next stage drops 30 fraction bits
  localparam int PW = 66;
  logic signed [PW-1:0] pp_r [3][3];
  logic signed [PW-1:0] qp_r [3];
  logic signed [CW:0] omc2_r;
  logic signed [CW-1:0] c2_r;
  flags_t f2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) pp_r[i][j] <= PW'(u1_r[i]) * PW'(u1_r[j]);
        qp_r[i] <= PW'(s1_r) * PW'(u1_r[i]);
      end
      omc2_r <= (CW+1)'(OneQ30) - (CW+1)'(c1_r);
      c2_r <= c1_r;
      f2_r <= f1_r;
    end
  end

  logic signed [35:0] p3_r [3][3];
  logic signed [35:0] q3_r [3];
  logic signed [CW:0] omc3_r;
  logic signed [CW-1:0] c3_r;
  flags_t f3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) p3_r[i][j] <= 36'(pp_r[i][j] >>> 30);
        q3_r[i] <= 36'(qp_r[i] >>> 30);
      end
      omc3_r <= omc2_r; c3_r <= c2_r; f3_r <= f2_r;
    end
  end

  logic signed [71:0] tp_r [3][3];
  logic signed [35:0] q4_r [3];
  logic signed [CW-1:0] c4_r;
  flags_t f4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) tp_r[i][j] <= 72'(omc3_r) * 72'(p3_r[i][j]);
      end
      q4_r <= q3_r; c4_r <= c3_r; f4_r <= f3_r;
    end
  end

  logic signed [37:0] m5_r [9];
  flags_t f5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m5_r[0] <= 38'(c4_r) + 38'(tp_r[0][0] >>> 30);
      m5_r[1] <= 38'(tp_r[0][1] >>> 30) + 38'(q4_r[2]);
      m5_r[2] <= 38'(tp_r[0][2] >>> 30) - 38'(q4_r[1]);
      m5_r[3] <= 38'(tp_r[1][0] >>> 30) - 38'(q4_r[2]);
      m5_r[4] <= 38'(c4_r) + 38'(tp_r[1][1] >>> 30);
      m5_r[5] <= 38'(tp_r[1][2] >>> 30) + 38'(q4_r[0]);
      m5_r[6] <= 38'(tp_r[2][0] >>> 30) + 38'(q4_r[1]);
      m5_r[7] <= 38'(tp_r[2][1] >>> 30) - 38'(q4_r[0]);
      m5_r[8] <= 38'(c4_r) + 38'(tp_r[2][2] >>> 30);
      f5_r <= f4_r;
    end
  end

  logic [OutW:0] res6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        logic signed [37:0] r;
        r = (m5_r[i] + 38'sd32768) >>> 16;
        if (f5_r.zero) r = '0;
        else if (r > EntryMax) r = 38'(EntryMax);
        else if (r < -EntryMax) r = -38'(EntryMax);
        res6_r[i*EntryW +: EntryW] <= EntryW'(r);
      end
      res6_r[OutW] <= f5_r.zero;
    end
  end
  assign res_data = res6_r;

  // skid FIFO
  logic pop;
  assign pop = out_tvalid && out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      if (res_valid) begin
        sk_r[wr_r] <= res_data;
        wr_r <= ~wr_r;
      end
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(res_valid) - 2'(pop);
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata = {8'd0, sk_r[rd_r][OutW-1:0]};
  assign out_tuser = sk_r[rd_r][OutW];

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("skid overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && cnt_r == 2'd2 && !pop)) else $error("result dropped");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// ===== verif/axis_angle_rotation_matrix_tb.sv =====
`default_nettype none
module axis_angle_rotation_matrix_tb;
  import aarm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Iters = TRIG_ITERATIONS_DEF;
  localparam int Latency = 88;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic signed [AxisW-1:0] ax;
    logic signed [AxisW-1:0] ay;
    logic signed [AxisW-1:0] az;
  } rot_req_t;

  typedef struct {
    logic signed [EntryW-1:0] m [9];
    logic zero;
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic out_tuser;

  matrix_t expected_mats[$];
  int mismatches = 0;
  longint cycles = 0;
  bit idle_off = 1'b0;
  int hold_cycles = 0;

  axis_angle_rotation_matrix uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint entry_q14(longint v);
    longint r;
    r = floor_shr(v + (64'sd1 <<< 15), 16);
    if (r > EntryMax) r = EntryMax;
    if (r < -EntryMax) r = -EntryMax;
    return r;
  endfunction

  function automatic longint atan_step(int i);
    longint t [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048575, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic matrix_t rotation_of(rot_req_t r);
    matrix_t res;
    longint a [3], u [3], q [3], t [3][3], mm [9];
    longint ang, x, y, z, dx, dy, s, c, omc, len, mag;
    longint unsigned n2;
    bit neg_cos;
    int n;
    a[0] = r.ax;
    a[1] = r.ay;
    a[2] = r.az;
    res.zero = 1'b0;
    if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
      foreach (res.m[k]) res.m[k] = '0;
      res.zero = 1'b1;
      return res;
    end
    n2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    len = int_sqrt(n2 << 28);
    for (int i = 0; i < 3; i++) begin
      mag = a[i] < 0 ? -a[i] : a[i];
      mag = longint'((unsigned'(mag) << 44) / unsigned'(len));
      u[i] = a[i] < 0 ? -mag : mag;
    end
    // fold angle into [-90,90] degrees
    ang = longint'(r.angle) % FullTurn;
    if (ang < 0) ang += FullTurn;
    if (ang > HalfTurn) ang -= FullTurn;
    neg_cos = 1'b0;
    if (ang > QuarterTurn) begin
      ang = HalfTurn - ang;
      neg_cos = 1'b1;
    end else if (ang < -QuarterTurn) begin
      ang = -HalfTurn - ang;
      neg_cos = 1'b1;
    end
    z = ang * 73204;
    x = 652032874;
    y = 0;
    n = Iters > TrigIterMax ? TrigIterMax : Iters;
    for (int i = 0; i < n; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    s = y;
    c = neg_cos ? -x : x;
    omc = (64'sd1 <<< 30) - c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++)
        t[i][j] = floor_shr(omc * floor_shr(u[i] * u[j], 30), 30);
      q[i] = floor_shr(s * u[i], 30);
    end
    mm[0] = c + t[0][0];
    mm[1] = t[0][1] + q[2];
    mm[2] = t[0][2] - q[1];
    mm[3] = t[1][0] - q[2];
    mm[4] = c + t[1][1];
    mm[5] = t[1][2] + q[0];
    mm[6] = t[2][0] + q[1];
    mm[7] = t[2][1] - q[0];
    mm[8] = c + t[2][2];
    foreach (mm[k]) res.m[k] = EntryW'(entry_q14(mm[k]));
    return res;
  endfunction

  task automatic send_rotation(rot_req_t r);
    if (!idle_off)
      while ($urandom_range(99) < 17) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    expected_mats.push_back(rotation_of(r));
    in_tdata <= {6'b0, r.az, r.ay, r.ax, r.angle};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic rot_req_t rand_rotation();
    rot_req_t r;
    r.angle = AngleW'($urandom_range(2 * FullTurn) - FullTurn);
    case ($urandom_range(3))
      0: r.angle = AngleW'($urandom());
      1: r.angle = AngleW'(($urandom_range(8) - 4) * QuarterTurn);
      default: ;
    endcase
    r.ax = AxisW'($urandom());
    r.ay = AxisW'($urandom());
    r.az = AxisW'($urandom());
    if ($urandom_range(9) == 0) r.ax = 0;
    if ($urandom_range(9) == 0) r.ay = 0;
    if ($urandom_range(9) == 0) r.az = 0;
    // short axes stress normalization
    if ($urandom_range(5) == 0) begin
      r.ax = AxisW'(signed'($urandom_range(6)) - 3);
      r.ay = AxisW'(signed'($urandom_range(6)) - 3);
      r.az = AxisW'(signed'($urandom_range(6)) - 3);
    end
    return r;
  endfunction

  task automatic test_directed();
    rot_req_t r;
    int angs [10] = '{0, QuarterTurn, -QuarterTurn, HalfTurn, -HalfTurn,
      FullTurn, -FullTurn, 131071, -131072, 11520};
    foreach (angs[k]) begin
      r.angle = AngleW'(angs[k]);
      r.ax = 16'sh7fff; r.ay = 0; r.az = 0;
      if (k % 3 == 1) begin r.ax = 0; r.ay = -16'sd32768; end
      if (k % 3 == 2) begin r.ax = 0; r.az = 16'sh7fff; end
      send_rotation(r);
    end
    r = '{angle: 18'sd5000, ax: 0, ay: 0, az: 0};
    send_rotation(r);
    r = '{angle: -18'sd92160, ax: 0, ay: 0, az: 0};
    send_rotation(r);
    r = '{angle: 18'sd7777, ax: -16'sd32768, ay: -16'sd32768, az: -16'sd32768};
    send_rotation(r);
    r = '{angle: -18'sd30000, ax: 16'sh7fff, ay: 16'sh7fff, az: 16'sh7fff};
    send_rotation(r);
    r = '{angle: 18'sd12345, ax: 1, ay: 0, az: 0};
    send_rotation(r);
    r = '{angle: 18'sd40000, ax: -1, ay: 1, az: -1};
    send_rotation(r);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_rotation(rand_rotation());
  endtask

  task automatic test_no_idle(int count);
    idle_off = 1'b1;
    test_random(count);
    idle_off = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    test_random(150);
  endtask

  // receiver: random stalls, always ready in the no-idle test, or a long hold when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= idle_off ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    matrix_t e;
    logic [EntryW-1:0] got;
    bit bad;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        e = expected_mats.pop_front();
        bad = (out_tuser !== e.zero);
        for (int k = 0; k < 9; k++) begin
          got = out_tdata[k*EntryW +: EntryW];
          if (got !== e.m[k]) bad = 1'b1;
        end
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch zero exp %b got %b", e.zero, out_tuser);
            for (int k = 0; k < 9; k++)
              $display("  m%0d exp %0d got %0d", k, e.m[k],
                       $signed(out_tdata[k*EntryW +: EntryW]));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(200);
    test_no_idle(120);
    test_backpressure();
    test_random(60);
    in_tvalid <= 1'b0;
    while (expected_mats.size() != 0) @(negedge clk);
    repeat (Latency + 20) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/aarm_pkg.sv
rtl/aarm_cordic.sv
rtl/aarm_norm.sv
rtl/axis_angle_rotation_matrix.sv
verif/axis_angle_rotation_matrix_tb.sv
